// File: hdl/lr_pkg.sv
// Shared types, constants and the control store of the linear resampler.
// No dependencies; used by lr_if.sv, lr_seq.sv and linear_resampler_top.sv.
package lr_pkg;

  localparam int unsigned SAMPLE_BITS    = 16;
  localparam int unsigned FRAC_BITS      = 16;
  localparam int unsigned MAX_OUT_PER_IN = 30;

  localparam int unsigned LEN_W  = 16;
  localparam int unsigned POS_W  = 16;
  localparam int unsigned STEP_W = 32;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned IDX_W  = 2;

  // register indexes (byte address = 4 * index)
  localparam logic [IDX_W-1:0] REG_IN_LENGTH  = 2'd0;
  localparam logic [IDX_W-1:0] REG_OUT_LENGTH = 2'd1;
  localparam logic [IDX_W-1:0] REG_STEP       = 2'd2;

  localparam int unsigned PC_W = 3;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t STEP_LATCH = 3'd0;
  localparam pc_t STEP_FIRST = 3'd1;
  localparam pc_t STEP_POS   = 3'd2;
  localparam pc_t STEP_MUL   = 3'd3;
  localparam pc_t STEP_EMIT  = 3'd4;
  localparam pc_t STEP_CLOSE = 3'd5;

  typedef enum logic [2:0] {
    ACT_LATCH,
    ACT_FIRST,
    ACT_POS,
    ACT_MUL,
    ACT_STEP,
    ACT_CLOSE
  } act_e;

  typedef enum logic [1:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_EXIT
  } cond_e;

  typedef struct packed {
    act_e  act;
    logic  wait_in;
    cond_e cond;
    pc_t   target;
  } ctl_t;

  typedef struct packed {
    logic in_fire;
    logic stall;
    logic loop_exit;
  } status_t;

  // control store: one word per step
  function automatic ctl_t ucode(pc_t pc);
    ctl_t w;
    case (pc)
      STEP_LATCH: w = '{act: ACT_LATCH, wait_in: 1'b1, cond: COND_NEVER,  target: STEP_LATCH};
      STEP_FIRST: w = '{act: ACT_FIRST, wait_in: 1'b0, cond: COND_NEVER,  target: STEP_LATCH};
      STEP_POS:   w = '{act: ACT_POS,   wait_in: 1'b0, cond: COND_EXIT,   target: STEP_CLOSE};
      STEP_MUL:   w = '{act: ACT_MUL,   wait_in: 1'b0, cond: COND_NEVER,  target: STEP_LATCH};
      STEP_EMIT:  w = '{act: ACT_STEP,  wait_in: 1'b0, cond: COND_ALWAYS, target: STEP_POS};
      STEP_CLOSE: w = '{act: ACT_CLOSE, wait_in: 1'b0, cond: COND_ALWAYS, target: STEP_LATCH};
      default:    w = '{act: ACT_LATCH, wait_in: 1'b1, cond: COND_ALWAYS, target: STEP_LATCH};
    endcase
    return w;
  endfunction

endpackage

// File: hdl/lr_if.sv
// Valid/ready stream interfaces for input samples and resampled results.
// Depends on lr_pkg for default widths.
interface lr_sample_if #(
  parameter int unsigned SAMPLE_BITS = lr_pkg::SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface lr_result_if #(
  parameter int unsigned SAMPLE_BITS = lr_pkg::SAMPLE_BITS
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] value;
  logic [lr_pkg::POS_W-1:0]      out_pos;
  logic                          block_end;

  modport source (output valid, output value, output out_pos, output block_end, input ready);
  modport sink   (input valid, input value, input out_pos, input block_end, output ready);
endinterface

// File: hdl/linear_resampler_top.sv
// Linear resampler: one sample per input transaction, outputs by linear interpolation.
// Flow: output 0 of a block is registered in the FIRST step after its sample is accepted; an
// interior output passes the POS, MUL and EMIT steps, and a final output the POS and CLOSE steps.
// A new sample is taken only once the position/multiply/emit loop of the sequencer around one
// multiplier and the CLOSE step are done; output stalls hold the sequencer in its step.
// Reset (rst_ni, async, active low) restores default registers and starts a new block.
module linear_resampler_top #(
  parameter int unsigned SAMPLE_BITS    = lr_pkg::SAMPLE_BITS,
  parameter int unsigned FRAC_BITS      = lr_pkg::FRAC_BITS,
  parameter int unsigned MAX_OUT_PER_IN = lr_pkg::MAX_OUT_PER_IN
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  lr_sample_if.sink                 sample_i,
  lr_result_if.source               result_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [lr_pkg::ADDR_W-1:0] paddr,
  input  logic [lr_pkg::DATA_W-1:0] pwdata,
  output logic [lr_pkg::DATA_W-1:0] prdata,
  output logic                      pready
);

  localparam int unsigned LEN_W  = lr_pkg::LEN_W;
  localparam int unsigned POS_W  = lr_pkg::POS_W;
  localparam int unsigned STEP_W = lr_pkg::STEP_W;
  localparam int unsigned DATA_W = lr_pkg::DATA_W;
  localparam int unsigned ADDR_W = lr_pkg::ADDR_W;
  localparam int unsigned RW     = STEP_W - FRAC_BITS + 1;
  localparam int unsigned CW     = STEP_W + 1;
  localparam int unsigned DW     = SAMPLE_BITS + 1;
  localparam int unsigned PW     = SAMPLE_BITS + FRAC_BITS + 2;
  localparam int unsigned IW     = $clog2(MAX_OUT_PER_IN + 1);

  // configuration
  logic [LEN_W-1:0]  in_length_q, out_length_q;
  logic [STEP_W-1:0] step_q;
  logic              cfg_wr;
  logic [lr_pkg::IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_length_q  <= LEN_W'(2);
      out_length_q <= LEN_W'(2);
      step_q       <= STEP_W'(65536);
    end else if (cfg_wr) begin
      case (cfg_idx)
        lr_pkg::REG_IN_LENGTH:  in_length_q  <= pwdata[LEN_W-1:0];
        lr_pkg::REG_OUT_LENGTH: out_length_q <= pwdata[LEN_W-1:0];
        lr_pkg::REG_STEP:       step_q       <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      lr_pkg::REG_IN_LENGTH:  prdata = DATA_W'(in_length_q);
      lr_pkg::REG_OUT_LENGTH: prdata = DATA_W'(out_length_q);
      lr_pkg::REG_STEP:       prdata = DATA_W'(step_q);
      default:                prdata = '0;
    endcase
  end

  // sequencer
  lr_pkg::ctl_t    ctl;
  lr_pkg::status_t status;

  lr_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctl_o    (ctl)
  );

  // block state
  logic [LEN_W-1:0]              count_q;
  logic signed [SAMPLE_BITS-1:0] prev_sample_q;
  logic [STEP_W-1:0]             acc_q;
  logic [POS_W-1:0]              nidx_q;
  logic signed [SAMPLE_BITS-1:0] prev_out_q;
  logic [IW-1:0]                 interior_q;

  // working registers
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic [STEP_W-1:0]             rel_q;
  logic signed [SAMPLE_BITS-1:0] lo_q;
  logic signed [PW-1:0]          prod_q;

  // output register
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_value_q;
  logic [POS_W-1:0]              out_pos_q;
  logic                          out_end_q;

  logic [LEN_W-1:0]  eff_in, ol, ol_m1;
  logic              last;
  logic [STEP_W-1:0] rel_sum;
  logic [RW-1:0]     r_pos;
  logic              r_lt, r_gt_n, loop_exit;
  logic signed [DW-1:0] diff;
  logic signed [PW-1:0] blend_t;
  logic signed [SAMPLE_BITS-1:0] blend_v;
  logic                          in_fire;
  logic                          emit_req, stall, en;
  logic signed [SAMPLE_BITS-1:0] emit_value;
  logic [POS_W-1:0]              emit_pos;
  logic                          emit_end;

  always_comb begin
    eff_in  = (in_length_q == '0) ? LEN_W'(1) : in_length_q;
    ol      = (out_length_q == '0) ? LEN_W'(1) : out_length_q;
    ol_m1   = ol - 1'b1;
    last    = ({1'b0, count_q} + (LEN_W+1)'(1)) >= {1'b0, eff_in};

    rel_sum = acc_q + step_q;
    r_pos   = RW'(rel_sum[STEP_W-1:FRAC_BITS]) + RW'(1);
    r_lt    = CW'(r_pos) < CW'(eff_in);
    r_gt_n  = CW'(r_pos) > CW'(count_q);
    loop_exit = (nidx_q >= ol_m1) || (r_lt ? r_gt_n : !last);

    diff    = DW'(x_q) - DW'(lo_q);
    // floor((lo << F) + f*(hi-lo) + half) keeps ties toward +inf
    blend_t = (PW'(lo_q) <<< FRAC_BITS) + prod_q + (PW'(1) <<< (FRAC_BITS - 1));
    blend_v = blend_t[FRAC_BITS +: SAMPLE_BITS];
  end

  assign sample_i.ready = (ctl.act == lr_pkg::ACT_LATCH);
  assign in_fire        = sample_i.valid && sample_i.ready;

  always_comb begin
    emit_req   = 1'b0;
    emit_value = x_q;
    emit_pos   = '0;
    emit_end   = 1'b0;
    case (ctl.act)
      lr_pkg::ACT_FIRST: begin
        emit_req = (count_q == '0) && (ol >= LEN_W'(2));
      end
      lr_pkg::ACT_STEP: begin
        emit_req   = interior_q < IW'(MAX_OUT_PER_IN);
        emit_value = blend_v;
        emit_pos   = nidx_q;
      end
      lr_pkg::ACT_CLOSE: begin
        emit_req = last;
        emit_pos = ol_m1;
        emit_end = 1'b1;
      end
      default: ;
    endcase
    stall = emit_req && out_valid_q && !result_o.ready;
    en    = !stall;
  end

  assign status = '{in_fire: in_fire, stall: stall, loop_exit: loop_exit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= '0;
      prev_sample_q <= '0;
      acc_q         <= '0;
      nidx_q        <= POS_W'(1);
      prev_out_q    <= '0;
      interior_q    <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (emit_req && en) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (ctl.act)
        lr_pkg::ACT_LATCH: begin
          if (in_fire) begin
            interior_q <= '0;
          end
        end
        lr_pkg::ACT_FIRST: begin
          if (emit_req && en) begin
            prev_out_q <= x_q;
          end
        end
        lr_pkg::ACT_STEP: begin
          if (en) begin
            acc_q      <= rel_q;
            prev_out_q <= blend_v;
            nidx_q     <= nidx_q + 1'b1;
            if (emit_req) begin
              interior_q <= interior_q + 1'b1;
            end
          end
        end
        lr_pkg::ACT_CLOSE: begin
          if (en) begin
            prev_sample_q <= x_q;
            if (last) begin
              prev_out_q <= x_q;
              count_q    <= '0;
              acc_q      <= '0;
              nidx_q     <= POS_W'(1);
            end else begin
              count_q <= count_q + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q <= sample_i.sample;
    end
    if (ctl.act == lr_pkg::ACT_POS) begin
      rel_q <= rel_sum;
      lo_q  <= r_lt ? prev_sample_q : prev_out_q;
    end
    if (ctl.act == lr_pkg::ACT_MUL) begin
      prod_q <= PW'($signed({1'b0, rel_q[FRAC_BITS-1:0]}) * diff);
    end
    if (emit_req && en) begin
      out_value_q <= emit_value;
      out_pos_q   <= emit_pos;
      out_end_q   <= emit_end;
    end
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.value     = out_value_q;
  assign result_o.out_pos   = out_pos_q;
  assign result_o.block_end = out_end_q;

`ifndef ASSERT_OFF
  a_latch_then_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> ctl.act == lr_pkg::ACT_FIRST)
    else $error("sequencer did not move on after input transaction");

  a_step_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.act == lr_pkg::ACT_STEP && en) |=> nidx_q == $past(nidx_q) + 1'b1)
    else $error("output index did not advance");

  a_block_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.act == lr_pkg::ACT_CLOSE && en && last) |=>
      (count_q == '0 && acc_q == '0 && nidx_q == POS_W'(1)))
    else $error("block counters not cleared at block end");

  a_interior_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.act == lr_pkg::ACT_STEP && !emit_req) |-> interior_q == IW'(MAX_OUT_PER_IN))
    else $error("interior output dropped below per-sample limit");
`endif

endmodule

// File: hdl/lr_seq.sv
// Step counter and control store of the resampler sequencer.
// Depends on lr_pkg (control word, status and step constants).
module lr_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lr_pkg::status_t status_i,
  output lr_pkg::ctl_t    ctl_o
);

  lr_pkg::pc_t pc_q, pc_d;
  logic        hold;
  logic        jump;

  assign ctl_o = lr_pkg::ucode(pc_q);

  always_comb begin
    hold = (ctl_o.wait_in && !status_i.in_fire) || status_i.stall;
    case (ctl_o.cond)
      lr_pkg::COND_NEVER:  jump = 1'b0;
      lr_pkg::COND_ALWAYS: jump = 1'b1;
      lr_pkg::COND_EXIT:   jump = status_i.loop_exit;
      default:             jump = 1'b0;
    endcase
    if (hold) begin
      pc_d = pc_q;
    end else if (jump) begin
      pc_d = ctl_o.target;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= lr_pkg::STEP_LATCH;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule
